// ===== rtl/core/blvf_pkg.sv =====
package blvf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = 17;
    localparam int COEFF_W  = 16;
    localparam int GAIN_W   = 15;
    localparam int RES_W    = 32;
    localparam int ACC_W    = 50;
    localparam int MULA_W   = 33;
    localparam int MULB_W   = 26;
    localparam int PROD_W   = MULA_W + MULB_W;
    localparam int MAG_W    = 25;
    localparam int MIX_W    = 44;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [COEFF_W-1:0]  coeff_t;
    typedef logic        [GAIN_W-1:0]   gain_t;
    typedef logic signed [RES_W-1:0]    res_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [MULA_W-1:0]   mula_t;
    typedef logic signed [MULB_W-1:0]   mulb_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic        [MAG_W-1:0]    mag_t;
    typedef logic signed [MIX_W-1:0]    mix_t;
    typedef logic        [ADDR_W-1:0]   addr_t;
    typedef logic        [DATA_W-1:0]   data_t;
    typedef logic        [1:0]          reg_idx_t;

    localparam reg_idx_t REG_POLE_ONE   = 2'd0;
    localparam reg_idx_t REG_POLE_TWO   = 2'd1;
    localparam reg_idx_t REG_INPUT_GAIN = 2'd2;

    localparam gain_t GAIN_RESET = 15'h7FFF;

endpackage

// ===== rtl/core/blvf_in_if.sv =====
interface blvf_in_if;
    logic              valid;
    logic              ready;
    blvf_pkg::sample_t mouth_pressure;
    blvf_pkg::sample_t bore_pressure;

    modport source (output valid, output mouth_pressure, output bore_pressure, input ready);
    modport sink   (input valid, input mouth_pressure, input bore_pressure, output ready);
endinterface

// ===== rtl/core/blvf_out_if.sv =====
interface blvf_out_if;
    logic              valid;
    logic              ready;
    blvf_pkg::sample_t lip_output;

    modport source (output valid, output lip_output, input ready);
    modport sink   (input valid, input lip_output, output ready);
endinterface

// ===== rtl/core/brass_lip_valve_filter_unit.sv =====
// Brass lip valve filter: each input word (mouth and bore pressure, Q1.15) drives a two-pole
// resonator y = g*(mouth-bore) + a1*y1 + a2*y2 held in saturating Q8.24; the squared output,
// clamped at 1.0, is the lip opening area, and the result word is
// area*mouth + (1-area)*bore in Q1.15, saturated. All five products go one after another
// through a single shared 33x26 multiplier under a small sequencer, and the input stays not
// ready until the result is in the output register, so a new word is accepted only once the
// last one is through. The result is loaded only when the output register is free.
// A finished result waits in the output register while the next word is accepted.
// Coefficients are written over the APB port: a1 at 0x0, a2 at 0x4 (Q2.14), gain at 0x8 (Q0.15).
module brass_lip_valve_filter_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  blvf_pkg::addr_t        paddr,
    input  blvf_pkg::data_t        pwdata,
    output blvf_pkg::data_t        prdata,
    output logic                   pready,
    blvf_in_if.sink                sample_in,
    blvf_out_if.source             lip_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_POLE_ONE,
        S_POLE_TWO,
        S_SUM,
        S_ROUND,
        S_MAG,
        S_SQUARE,
        S_AREA,
        S_MIX,
        S_DONE
    } state_t;

    localparam blvf_pkg::acc_t   ROUND_Y   = 50'sd8192;
    localparam logic signed [35:0] Y_MAX   = 36'sh07FFFFFFF;
    localparam logic signed [35:0] Y_MIN   = -36'sh080000000;
    localparam logic [31:0]      ONE_Q24   = 32'h0100_0000;
    localparam blvf_pkg::mag_t   AREA_ONE  = 25'h100_0000;
    localparam logic [49:0]      ROUND_SQ  = 50'h80_0000;
    localparam blvf_pkg::mix_t   ROUND_MIX = 44'sh80_0000;
    localparam logic signed [19:0] MIX_MAX = 20'sd32767;
    localparam logic signed [19:0] MIX_MIN = -20'sd32768;

    state_t                state_reg;
    blvf_pkg::coeff_t      pole_one_reg;
    blvf_pkg::coeff_t      pole_two_reg;
    blvf_pkg::gain_t       gain_reg;
    blvf_pkg::sample_t     bore_reg;
    blvf_pkg::diff_t       diff_reg;
    blvf_pkg::res_t        y1_reg;
    blvf_pkg::res_t        y2_reg;
    blvf_pkg::acc_t        acc_reg;
    blvf_pkg::prod_t       prod_reg;
    blvf_pkg::mag_t        mag_reg;
    logic                  big_reg;
    blvf_pkg::mag_t        area_reg;
    blvf_pkg::sample_t     out_reg;
    logic                  out_valid_reg;

    blvf_pkg::mula_t       mul_a;
    blvf_pkg::mulb_t       mul_b;
    blvf_pkg::prod_t       mul_p;
    blvf_pkg::acc_t        acc_round;
    logic signed [35:0]    y_wide;
    blvf_pkg::res_t        y_sat;
    logic [31:0]           y_abs;
    logic [49:0]           sq_round;
    blvf_pkg::mix_t        mix_sum;
    logic signed [19:0]    mix_q;
    blvf_pkg::sample_t     mix_sat;
    logic                  cfg_write;
    logic                  out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_one_reg <= '0;
            pole_two_reg <= '0;
            gain_reg     <= blvf_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                blvf_pkg::REG_POLE_ONE:   pole_one_reg <= pwdata[15:0];
                blvf_pkg::REG_POLE_TWO:   pole_two_reg <= pwdata[15:0];
                blvf_pkg::REG_INPUT_GAIN: gain_reg     <= pwdata[14:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            blvf_pkg::REG_POLE_ONE:   prdata = {16'b0, pole_one_reg};
            blvf_pkg::REG_POLE_TWO:   prdata = {16'b0, pole_two_reg};
            blvf_pkg::REG_INPUT_GAIN: prdata = {17'b0, gain_reg};
            default:                  prdata = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_GAIN:
            begin
                mul_a = blvf_pkg::mula_t'(diff_reg);
                mul_b = blvf_pkg::mulb_t'({1'b0, gain_reg});
            end
            S_POLE_ONE:
            begin
                mul_a = blvf_pkg::mula_t'(y1_reg);
                mul_b = blvf_pkg::mulb_t'(pole_one_reg);
            end
            S_POLE_TWO:
            begin
                mul_a = blvf_pkg::mula_t'(y2_reg);
                mul_b = blvf_pkg::mulb_t'(pole_two_reg);
            end
            S_SQUARE:
            begin
                mul_a = blvf_pkg::mula_t'({1'b0, mag_reg});
                mul_b = blvf_pkg::mulb_t'({1'b0, mag_reg});
            end
            S_MIX:
            begin
                mul_a = blvf_pkg::mula_t'(diff_reg);
                mul_b = blvf_pkg::mulb_t'({1'b0, area_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // resonator rounding and saturation
    assign acc_round = acc_reg + ROUND_Y;
    assign y_wide    = acc_round[blvf_pkg::ACC_W-1:14];

    always_comb
    begin
        if (y_wide > Y_MAX)
            y_sat = 32'sh7FFF_FFFF;
        else if (y_wide < Y_MIN)
            y_sat = 32'sh8000_0000;
        else
            y_sat = y_wide[31:0];
    end

    assign y_abs    = y1_reg[31] ? 32'(-y1_reg) : 32'(y1_reg);
    assign sq_round = {1'b0, prod_reg[48:0]} + ROUND_SQ;

    // mix: area*diff + bore*2^24, rounded to Q1.15
    assign mix_sum = blvf_pkg::mix_t'(prod_reg)
                   + (blvf_pkg::mix_t'(bore_reg) <<< 24)
                   + ROUND_MIX;
    assign mix_q   = mix_sum[43:24];

    always_comb
    begin
        if (mix_q > MIX_MAX)
            mix_sat = 16'sh7FFF;
        else if (mix_q < MIX_MIN)
            mix_sat = 16'sh8000;
        else
            mix_sat = mix_q[15:0];
    end

    assign out_free = !out_valid_reg || lip_out.ready;

    assign sample_in.ready    = (state_reg == S_IDLE);
    assign lip_out.valid      = out_valid_reg;
    assign lip_out.lip_output = out_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            bore_reg      <= '0;
            diff_reg      <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            mag_reg       <= '0;
            big_reg       <= 1'b0;
            area_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (lip_out.valid && lip_out.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_in.valid)
                    begin
                        bore_reg  <= sample_in.bore_pressure;
                        diff_reg  <= blvf_pkg::diff_t'(sample_in.mouth_pressure)
                                   - blvf_pkg::diff_t'(sample_in.bore_pressure);
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_POLE_ONE;
                end
                S_POLE_ONE:
                begin
                    prod_reg  <= mul_p;
                    acc_reg   <= blvf_pkg::acc_t'(prod_reg) <<< 8;
                    state_reg <= S_POLE_TWO;
                end
                S_POLE_TWO:
                begin
                    prod_reg  <= mul_p;
                    acc_reg   <= acc_reg + blvf_pkg::acc_t'(prod_reg);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    acc_reg   <= acc_reg + blvf_pkg::acc_t'(prod_reg);
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    y2_reg    <= y1_reg;
                    y1_reg    <= y_sat;
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    mag_reg   <= y_abs[blvf_pkg::MAG_W-1:0];
                    big_reg   <= (y_abs > ONE_Q24);
                    state_reg <= S_SQUARE;
                end
                S_SQUARE:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_AREA;
                end
                S_AREA:
                begin
                    area_reg  <= big_reg ? AREA_ONE : sq_round[48:24];
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg       <= mix_sat;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/brass_lip_valve_filter_unit_test.sv =====
`timescale 1ns / 1ps

module brass_lip_valve_filter_unit_test;

    typedef struct packed {
        blvf_pkg::sample_t mouth;
        blvf_pkg::sample_t bore;
    } pressure_pair_t;

    localparam blvf_pkg::addr_t POLE_ONE_ADDR   =
        blvf_pkg::addr_t'({blvf_pkg::REG_POLE_ONE, 2'b00});
    localparam blvf_pkg::addr_t POLE_TWO_ADDR   =
        blvf_pkg::addr_t'({blvf_pkg::REG_POLE_TWO, 2'b00});
    localparam blvf_pkg::addr_t INPUT_GAIN_ADDR =
        blvf_pkg::addr_t'({blvf_pkg::REG_INPUT_GAIN, 2'b00});
    localparam blvf_pkg::addr_t SPARE_REG_ADDR  = 4'hC;

    localparam blvf_pkg::sample_t P_MAX = 16'sh7FFF;
    localparam blvf_pkg::sample_t P_MIN = 16'sh8000;

    localparam longint ONE_Q24   = 64'sd16777216;
    localparam longint RES_HALF  = 64'sd8192;
    localparam longint MIX_HALF  = 64'sd8388608;
    localparam longint RES_MAX   = 64'sd2147483647;
    localparam longint RES_MIN   = -64'sd2147483648;
    localparam longint OUT_MAX   = 64'sd32767;
    localparam longint OUT_MIN   = -64'sd32768;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 138;
    localparam int STALL_AT      = 600;
    localparam int STALL_CYCLES  = 400;
    localparam int REPORT_LIMIT  = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    blvf_pkg::addr_t paddr = '0;
    blvf_pkg::data_t pwdata = '0;
    blvf_pkg::data_t prdata;
    logic            pready;

    logic              send_valid = 1'b0;
    blvf_pkg::sample_t send_mouth = '0;
    blvf_pkg::sample_t send_bore = '0;
    logic              take_ready = 1'b0;

    blvf_in_if  sample_if ();
    blvf_out_if lip_if ();

    assign sample_if.valid          = send_valid;
    assign sample_if.mouth_pressure = send_mouth;
    assign sample_if.bore_pressure  = send_bore;
    assign lip_if.ready             = take_ready;

    brass_lip_valve_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sample_in (sample_if),
        .lip_out   (lip_if)
    );

    blvf_pkg::coeff_t model_a1 = '0;
    blvf_pkg::coeff_t model_a2 = '0;
    blvf_pkg::gain_t  model_gain = blvf_pkg::GAIN_RESET;
    blvf_pkg::res_t   model_y1 = '0;
    blvf_pkg::res_t   model_y2 = '0;

    pressure_pair_t    pending_words[$];
    pressure_pair_t    next_word;
    blvf_pkg::sample_t expected_lip_words[$];

    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int send_gap = 0;
    int recv_gap = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    int words_checked = 0;
    int fail_count = 0;

    always #2 clk = ~clk;

    function automatic blvf_pkg::sample_t predict_lip_word(blvf_pkg::sample_t mouth,
                                                           blvf_pkg::sample_t bore);
        longint diff;
        longint acc;
        longint y;
        longint area;
        longint mix;
        longint unsigned mag;
        longint unsigned sq;
        diff = longint'(mouth) - longint'(bore);
        acc = longint'(model_gain) * diff * 256
            + longint'(model_a1) * longint'(model_y1)
            + longint'(model_a2) * longint'(model_y2);
        y = (acc + RES_HALF) >>> 14;
        if (y > RES_MAX)
            y = RES_MAX;
        else if (y < RES_MIN)
            y = RES_MIN;
        model_y2 = model_y1;
        model_y1 = blvf_pkg::res_t'(y);
        mag = (y < 0) ? -y : y;
        sq = mag * mag;
        if (sq > (64'd1 << 48))
            area = ONE_Q24;
        else
            area = (sq + (64'd1 << 23)) >> 24;
        if (area > ONE_Q24)
            area = ONE_Q24;
        mix = area * longint'(mouth) + (ONE_Q24 - area) * longint'(bore);
        mix = (mix + MIX_HALF) >>> 24;
        if (mix > OUT_MAX)
            mix = OUT_MAX;
        else if (mix < OUT_MIN)
            mix = OUT_MIN;
        return blvf_pkg::sample_t'(mix);
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
        end
        else if (!send_valid || sample_if.ready)
        begin
            if (send_valid)
                expected_lip_words.push_back(predict_lip_word(send_mouth, send_bore));
            if (send_gap > 0)
            begin
                send_gap--;
                send_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                next_word = pending_words.pop_front();
                send_mouth <= next_word.mouth;
                send_bore <= next_word.bore;
                send_valid <= 1'b1;
                if (send_idle_on && $urandom_range(0, 2) == 0)
                    send_gap = gap_length();
            end
            else
            begin
                send_valid <= 1'b0;
            end
        end
    end

    task automatic check_lip_word(blvf_pkg::sample_t got);
        blvf_pkg::sample_t want;
        words_checked++;
        if (expected_lip_words.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("lip word %0d with none expected", got);
        end
        else
        begin
            want = expected_lip_words.pop_front();
            if (got !== want)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("lip word %0d: expected %0d, got %0d", words_checked, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (lip_if.valid && take_ready)
                check_lip_word(lip_if.lip_output);
            if (stall_left > 0)
            begin
                stall_left--;
                take_ready <= 1'b0;
            end
            else if (!stall_done && words_checked >= STALL_AT)
            begin
                // hold off long so the input side backs up
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                take_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                take_ready <= 1'b0;
            end
            else if (recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                recv_gap = gap_length() - 1;
                take_ready <= 1'b0;
            end
            else
            begin
                take_ready <= 1'b1;
            end
        end
    end

    task automatic write_register(blvf_pkg::addr_t addr, blvf_pkg::data_t value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (blvf_pkg::reg_idx_t'(addr[blvf_pkg::ADDR_W-1:2]))
            blvf_pkg::REG_POLE_ONE:   model_a1 = value[blvf_pkg::COEFF_W-1:0];
            blvf_pkg::REG_POLE_TWO:   model_a2 = value[blvf_pkg::COEFF_W-1:0];
            blvf_pkg::REG_INPUT_GAIN: model_gain = value[blvf_pkg::GAIN_W-1:0];
            default:                  ;
        endcase
    endtask

    task automatic set_coefficients(blvf_pkg::coeff_t a1, blvf_pkg::coeff_t a2,
                                    blvf_pkg::gain_t gain);
        blvf_pkg::data_t junk;
        junk = $urandom;
        write_register(POLE_ONE_ADDR, {junk[31:16], a1});
        junk = $urandom;
        write_register(POLE_TWO_ADDR, {junk[31:16], a2});
        junk = $urandom;
        write_register(INPUT_GAIN_ADDR, {junk[31:15], gain});
        write_register(SPARE_REG_ADDR, $urandom);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() > 0 || send_valid || expected_lip_words.size() > 0);
    endtask

    task automatic queue_word(blvf_pkg::sample_t mouth, blvf_pkg::sample_t bore);
        pressure_pair_t w;
        w.mouth = mouth;
        w.bore = bore;
        pending_words.push_back(w);
    endtask

    function automatic blvf_pkg::sample_t pick_corner();
        case ($urandom_range(0, 4))
            0: return P_MAX;
            1: return P_MIN;
            2: return 16'sh0000;
            3: return 16'sh0001;
            default: return 16'shFFFF;
        endcase
    endfunction

    task automatic queue_random_words(int count);
        blvf_pkg::sample_t mouth;
        blvf_pkg::sample_t bore;
        int style;
        mouth = '0;
        bore = '0;
        @(negedge clk);
        repeat (count)
        begin
            style = $urandom_range(0, 99);
            if (style < 40)
            begin
                mouth = blvf_pkg::sample_t'($urandom);
                bore = blvf_pkg::sample_t'($urandom);
            end
            else if (style < 60)
            begin
                mouth = blvf_pkg::sample_t'(int'($urandom_range(0, 4000)) - 2000);
                bore = blvf_pkg::sample_t'(int'($urandom_range(0, 4000)) - 2000);
            end
            else if (style < 75)
            begin
                // sustained blowing, bore wanders
                bore = blvf_pkg::sample_t'(int'($urandom_range(0, 16000)) - 8000);
            end
            else if (style < 88)
            begin
                mouth = pick_corner();
                bore = pick_corner();
            end
            queue_word(mouth, bore);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset coefficients: pure gain path, area follows the pressure drop
        @(negedge clk);
        queue_word(P_MAX, P_MIN);
        queue_word(P_MIN, P_MAX);
        queue_word(16'sh0000, 16'sh0000);
        queue_word(P_MAX, P_MAX);
        queue_word(P_MIN, P_MIN);
        queue_word(16'sh4000, 16'sh0000);
        queue_word(16'sh0000, 16'sh4000);
        queue_word(16'sh0001, 16'shFFFF);
        queue_word(16'shFFFF, 16'sh0000);
        queue_word(16'sh5A82, 16'sh0000);
        queue_word(P_MAX, 16'sh0000);
        queue_word(P_MIN, 16'sh0000);
        wait_drained();

        // runaway resonator, saturate both ways
        set_coefficients(16'sh7FFF, 16'sh7FFF, 15'h7FFF);
        @(negedge clk);
        repeat (4) queue_word(P_MAX, P_MIN);
        repeat (3) queue_word(P_MIN, P_MAX);
        wait_drained();
        set_coefficients(16'sh8000, 16'sh8000, 15'h0000);
        @(negedge clk);
        repeat (3) queue_word(16'sh1234, 16'shEDCC);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 6)
                0: set_coefficients(16'sh7F9D, -16'sd16285, 15'd983);
                1: set_coefficients(16'sh7FFF, 16'sh7FFF, 15'h7FFF);
                2: set_coefficients(16'sh8000, 16'sh8000, 15'h0000);
                3: set_coefficients(16'sh8000, 16'sh7FFF, 15'h7FFF);
                4: set_coefficients(blvf_pkg::coeff_t'($urandom),
                                    blvf_pkg::coeff_t'($urandom),
                                    blvf_pkg::gain_t'($urandom));
                default: set_coefficients(
                             blvf_pkg::coeff_t'($urandom_range(28000, 32700)),
                             blvf_pkg::coeff_t'(-int'($urandom_range(15000, 16384))),
                             blvf_pkg::gain_t'($urandom_range(0, 4000)));
            endcase
            send_idle_on = (phase != 2);
            recv_idle_on = (phase != 2);
            queue_random_words(PHASE_WORDS);
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (fail_count == 0 && expected_lip_words.size() == 0)
            $display("[brass_lip_valve_filter_unit] OK");
        else
            $display("[brass_lip_valve_filter_unit] ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("[brass_lip_valve_filter_unit] ERROR");
        $finish;
    end

endmodule
